>>> sv/jtl_pkg.sv
// Package for the JSON table lexer: state, action and token codes, table functions, result type.
`timescale 1ns / 1ps

package jtl_pkg;

  // Lexer states.
  typedef enum logic [4:0] {
    S_IDLE      = 5'd0,
    S_PUNCT     = 5'd1,
    S_N         = 5'd2,
    S_NU        = 5'd3,
    S_NUL       = 5'd4,
    S_NULL      = 5'd5,
    S_T         = 5'd6,
    S_TR        = 5'd7,
    S_TRU       = 5'd8,
    S_TRUE      = 5'd9,
    S_F         = 5'd10,
    S_FA        = 5'd11,
    S_FAL       = 5'd12,
    S_FALS      = 5'd13,
    S_FALSE     = 5'd14,
    S_IDENT     = 5'd15,
    S_STR       = 5'd16,
    S_ESC       = 5'd17,
    S_STR_END   = 5'd18,
    S_SIGN      = 5'd19,
    S_SPACE     = 5'd20,
    S_INT       = 5'd21,
    S_DOT       = 5'd22,
    S_FRAC      = 5'd23,
    S_EXP       = 5'd24,
    S_EXP_SIGN  = 5'd25,
    S_EXP_DIG   = 5'd26
  } lex_state_e;

  // Actions taken on the held byte.
  typedef enum logic [3:0] {
    A_NONE       = 4'd0,
    A_PUNCT      = 4'd1,
    A_END_STR    = 4'd2,
    A_END_NUM    = 4'd3,
    A_END_NULL   = 4'd4,
    A_END_TRUE   = 4'd5,
    A_END_FALSE  = 4'd6,
    A_ERR_CHAR   = 4'd7,
    A_ERR_NUM    = 4'd8,
    A_CHAR       = 4'd9,
    A_INT_DIGIT  = 4'd10,
    A_FRAC_DIGIT = 4'd11,
    A_EXP_DIGIT  = 4'd12,
    A_NEG        = 4'd13,
    A_EXP_NEG    = 4'd14
  } action_e;

  // Token kinds on the result channel.
  typedef enum logic [3:0] {
    K_NONE       = 4'd0,
    K_PUNCT      = 4'd1,
    K_STRING_END = 4'd2,
    K_NUMBER     = 4'd3,
    K_NULL       = 4'd4,
    K_TRUE       = 4'd5,
    K_FALSE      = 4'd6,
    K_UNEXPECTED = 4'd7,
    K_INCOMPLETE = 4'd8
  } token_kind_e;

  typedef struct packed {
    logic               char_valid;
    logic [7:0]         char_out;
    logic [3:0]         token_kind;
    logic [63:0]        mantissa;
    logic               mantissa_saturated;
    logic               number_negative;
    logic signed [15:0] decimal_exponent;
  } result_t;

  function automatic logic is_digit(input logic [7:0] m);
    return (m >= "0") && (m <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] m);
    return ((m >= "a") && (m <= "z")) || ((m >= "A") && (m <= "Z"));
  endfunction

  function automatic logic is_punct(input logic [7:0] m);
    return (m == "{") || (m == "}") || (m == "[") || (m == "]") || (m == ",") || (m == ":");
  endfunction

  // Case-insensitive letter match against a lower-case letter.
  function automatic logic ci(input logic [7:0] m, input logic [7:0] lower);
    return (m == lower) || (m == (lower - 8'd32));
  endfunction

  function automatic lex_state_e next_of(input lex_state_e s, input logic [7:0] m);
    lex_state_e r;
    r = S_PUNCT;
    if (s == S_IDLE) begin
      r = S_IDLE;
      if (is_punct(m)) r = S_PUNCT;
      if (is_alpha(m) || (m == "_")) r = S_IDENT;
      if ((m == "+") || (m == "-")) r = S_SIGN;
      if (m == "\"") r = S_STR;
      if (ci(m, "n")) r = S_N;
      if (ci(m, "t")) r = S_T;
      if (ci(m, "f")) r = S_F;
    end
    if ((s >= S_N) && (s <= S_IDENT) &&
        (is_alpha(m) || is_digit(m) || (m == "-") || (m == "_") || (m == "."))) r = S_IDENT;
    if ((s == S_N) && ci(m, "u")) r = S_NU;
    if ((s == S_NU) && ci(m, "l")) r = S_NUL;
    if ((s == S_NUL) && ci(m, "l")) r = S_NULL;
    if ((s == S_T) && ci(m, "r")) r = S_TR;
    if ((s == S_TR) && ci(m, "u")) r = S_TRU;
    if ((s == S_TRU) && ci(m, "e")) r = S_TRUE;
    if ((s == S_F) && ci(m, "a")) r = S_FA;
    if ((s == S_FA) && ci(m, "l")) r = S_FAL;
    if ((s == S_FAL) && ci(m, "s")) r = S_FALS;
    if ((s == S_FALS) && ci(m, "e")) r = S_FALSE;
    if ((s == S_STR) || (s == S_ESC)) r = S_STR;
    if ((s == S_STR) && (m == "\\")) r = S_ESC;
    if ((s == S_STR) && (m == "\"")) r = S_STR_END;
    if (s == S_STR_END) r = S_PUNCT;
    if (((s == S_IDLE) || (s == S_SIGN) || (s == S_SPACE) || (s == S_INT)) && is_digit(m))
      r = S_INT;
    if (((s == S_STR_END) || (s == S_SPACE)) && (m >= 8'd1) && (m <= 8'd32)) r = S_SPACE;
    if (((s == S_IDLE) || (s == S_SIGN) || (s == S_SPACE) || (s == S_INT)) && (m == "."))
      r = S_DOT;
    if (((s == S_DOT) || (s == S_FRAC)) && is_digit(m)) r = S_FRAC;
    if (((s == S_INT) || (s == S_DOT) || (s == S_FRAC)) && ci(m, "e")) r = S_EXP;
    if ((s == S_EXP) && ((m == "+") || (m == "-"))) r = S_EXP_SIGN;
    if (((s == S_EXP) || (s == S_EXP_SIGN) || (s == S_EXP_DIG)) && is_digit(m)) r = S_EXP_DIG;
    return r;
  endfunction

  function automatic action_e act_of(input lex_state_e s, input logic [7:0] m);
    lex_state_e n;
    action_e    a;
    n = next_of(s, m);
    a = A_NONE;
    if ((s != S_IDLE) && (s < S_SIGN)) a = A_ERR_CHAR;
    if ((s == S_IDLE) && is_punct(m)) a = A_PUNCT;
    if ((n >= S_N) && (n <= S_IDENT)) a = A_CHAR;
    if (n == S_PUNCT) begin
      if (((s >= S_N) && (s <= S_NUL)) || ((s >= S_T) && (s <= S_TRU)) ||
          ((s >= S_F) && (s <= S_FALS))) a = A_END_STR;
      if (s == S_NULL) a = A_END_NULL;
      if (s == S_TRUE) a = A_END_TRUE;
      if (s == S_FALSE) a = A_END_FALSE;
      if (s == S_IDENT) a = A_END_STR;
    end
    if (s == S_STR) a = (n == S_STR) ? A_CHAR : A_NONE;
    if (s == S_ESC) a = A_CHAR;
    if (s == S_STR_END) a = A_END_STR;
    if (n == S_PUNCT) begin
      if (s >= S_SIGN) a = A_ERR_NUM;
      if ((s == S_INT) || (s == S_DOT) || (s == S_FRAC) || (s == S_EXP_DIG)) a = A_END_NUM;
    end
    if ((n == S_SIGN) && (m == "-")) a = A_NEG;
    if (n == S_INT) a = A_INT_DIGIT;
    if (n == S_FRAC) a = A_FRAC_DIGIT;
    if ((n == S_EXP_SIGN) && (m == "-")) a = A_EXP_NEG;
    if (n == S_EXP_DIG) a = A_EXP_DIGIT;
    return a;
  endfunction

endpackage

>>> sv/jtl_in_if.sv
// Byte input channel of the JSON table lexer.
`timescale 1ns / 1ps

interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> sv/jtl_out_if.sv
// Result channel of the JSON table lexer.
`timescale 1ns / 1ps

interface jtl_out_if;
  logic               valid;
  logic               ready;
  logic               char_valid;
  logic [7:0]         char_out;
  logic [3:0]         token_kind;
  logic [63:0]        mantissa;
  logic               mantissa_saturated;
  logic               number_negative;
  logic signed [15:0] decimal_exponent;

  modport source (output valid, output char_valid, output char_out, output token_kind,
                  output mantissa, output mantissa_saturated, output number_negative,
                  output decimal_exponent, input ready);
  modport sink   (input valid, input char_valid, input char_out, input token_kind,
                  input mantissa, input mantissa_saturated, input number_negative,
                  input decimal_exponent, output ready);
endinterface

>>> sv/json_table_lexer_unit.sv
// Top level of the byte-serial JSON table lexer with one byte of lookahead.
// Latency: the result for a held byte is loaded into the output register at the edge that
//   accepts the byte after it (the lookahead decides whether a token ends), and is offered
//   from the cycle that follows.
// Throughput: one byte per cycle unless the result register stalls; the lexer tables and
//   a shift-add digit update sit between the state registers and the result register.
// Reset: rst_ni clears lex state, held byte, number state and the output valid at once.
`timescale 1ns / 1ps

module json_table_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  jtl_in_if.sink      in_i,
  jtl_out_if.source   out_o
);
  import jtl_pkg::*;

  // Lexer state. The held byte is the one being acted on; the incoming beat is lookahead.
  lex_state_e  state_q, state_d;
  logic [7:0]  held_q;
  logic [63:0] acc_q, acc_d;
  logic        sat_q, sat_d;
  logic [15:0] frac_q, frac_d;
  logic [15:0] exp_q, exp_d;
  logic        vminus_q, vminus_d;
  logic        eminus_q, eminus_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  lex_state_e  cur_next;
  action_e     cur_act;
  action_e     look_act;
  logic [3:0]  digit;
  logic [67:0] mant_prod;
  logic [19:0] exp_prod;
  token_kind_e kind;
  logic        cv;
  logic        res_valid;
  logic        in_acc;
  logic signed [17:0] ev_sgn;
  logic signed [17:0] ev;

  // Accept a new byte whenever the result register is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Table lookups: act on the held byte, then look at what the next state does
  // with the lookahead byte.
  always_comb begin
    cur_next = next_of(state_q, held_q);
    cur_act  = act_of(state_q, held_q);
    look_act = act_of(cur_next, in_i.in_byte);
    digit    = held_q[3:0];
    // x*10 + d as shift-add; any bit above 63 means overflow.
    mant_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {64'b0, digit};
    exp_prod  = ({4'b0, exp_q} << 3) + ({4'b0, exp_q} << 1) + {16'b0, digit};
  end

  // Action on the held byte and token end detection.
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    frac_d   = frac_q;
    exp_d    = exp_q;
    vminus_d = vminus_q;
    eminus_d = eminus_q;
    kind     = K_NONE;
    cv       = 1'b0;

    unique case (cur_act)
      A_PUNCT:    kind = K_PUNCT;
      A_ERR_CHAR: kind = K_UNEXPECTED;
      A_ERR_NUM:  kind = K_INCOMPLETE;
      A_CHAR:     cv   = 1'b1;
      A_INT_DIGIT, A_FRAC_DIGIT: begin
        // Saturated mantissa holds; fraction digits still count.
        if (!sat_q) begin
          if (mant_prod[67:64] != 4'd0) begin
            acc_d = '1;
            sat_d = 1'b1;
          end else begin
            acc_d = mant_prod[63:0];
          end
        end
        if ((cur_act == A_FRAC_DIGIT) && (frac_q != 16'hFFFF)) frac_d = frac_q + 16'd1;
      end
      A_EXP_DIGIT: begin
        if (exp_prod[19:16] != 4'd0) exp_d = 16'hFFFF;
        else                         exp_d = exp_prod[15:0];
      end
      A_NEG:     vminus_d = 1'b1;
      A_EXP_NEG: eminus_d = 1'b1;
      default: ;
    endcase

    // Lookahead decides whether a string, number or literal ends on this byte.
    if (kind == K_NONE) begin
      unique case (look_act)
        A_END_STR:   kind = K_STRING_END;
        A_END_NUM:   kind = K_NUMBER;
        A_END_NULL:  kind = K_NULL;
        A_END_TRUE:  kind = K_TRUE;
        A_END_FALSE: kind = K_FALSE;
        default:     state_d = cur_next;
      endcase
    end

    res_valid = cv || (kind != K_NONE);

    // Exponent: signed exponent digits minus fraction digit count, clamped to 16 bits.
    ev_sgn = eminus_d ? -$signed({2'b00, exp_d}) : $signed({2'b00, exp_d});
    ev     = ev_sgn - $signed({2'b00, frac_d});

    res_d                    = '0;
    res_d.char_valid         = cv;
    res_d.token_kind         = kind;
    if (cv || (kind == K_PUNCT) || (kind == K_UNEXPECTED) || (kind == K_INCOMPLETE))
      res_d.char_out = held_q;
    if (kind == K_NUMBER) begin
      res_d.mantissa           = acc_d;
      res_d.mantissa_saturated = sat_d;
      res_d.number_negative    = vminus_d;
      if (ev > 18'sd32767)       res_d.decimal_exponent = 16'sh7FFF;
      else if (ev < -18'sd32768) res_d.decimal_exponent = 16'sh8000;
      else                       res_d.decimal_exponent = ev[15:0];
    end

    // Any token or error returns to idle and drops number state.
    if (kind != K_NONE) begin
      state_d  = S_IDLE;
      acc_d    = '0;
      sat_d    = 1'b0;
      frac_d   = '0;
      exp_d    = '0;
      vminus_d = 1'b0;
      eminus_d = 1'b0;
    end
  end

  // Output valid: load on accept, drop when the sink takes the beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc)            out_valid_d = res_valid;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      frac_q      <= '0;
      exp_q       <= '0;
      vminus_q    <= 1'b0;
      eminus_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        state_q  <= state_d;
        held_q   <= in_i.in_byte;
        acc_q    <= acc_d;
        sat_q    <= sat_d;
        frac_q   <= frac_d;
        exp_q    <= exp_d;
        vminus_q <= vminus_d;
        eminus_q <= eminus_d;
      end
    end
  end

  // Result payload needs no reset; valid qualifies it.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) res_q <= res_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.char_valid         = res_q.char_valid;
  assign out_o.char_out           = res_q.char_out;
  assign out_o.token_kind         = res_q.token_kind;
  assign out_o.mantissa           = res_q.mantissa;
  assign out_o.mantissa_saturated = res_q.mantissa_saturated;
  assign out_o.number_negative    = res_q.number_negative;
  assign out_o.decimal_exponent   = res_q.decimal_exponent;

endmodule

>>> sv/jtl_checker.sv
// Port-level assertions for the JSON table lexer, bound to its top level.
`timescale 1ns / 1ps

module jtl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        char_valid_i,
  input logic [3:0]  token_kind_i,
  input logic [63:0] mantissa_i,
  input logic [15:0] decimal_exponent_i
);
  import jtl_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Input is never blocked while the result register is empty.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // Every result beat carries a character or a token.
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (token_kind_i == K_NONE)) |-> char_valid_i)
    else $error("empty result beat");

  // Number fields are zero outside number tokens.
  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (token_kind_i != K_NUMBER)) |-> ((mantissa_i == 64'd0) &&
                                                     (decimal_exponent_i == 16'd0)))
    else $error("number fields set on non-number beat");

  // A passed character never shares a beat with punctuation or an error.
  a_char_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && char_valid_i) |-> ((token_kind_i != K_PUNCT) &&
                                       (token_kind_i != K_UNEXPECTED) &&
                                       (token_kind_i != K_INCOMPLETE)))
    else $error("character beat carries punctuation or error");

endmodule

bind json_table_lexer_unit jtl_checker u_jtl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .char_valid_i       (out_o.char_valid),
  .token_kind_i       (out_o.token_kind),
  .mantissa_i         (out_o.mantissa),
  .decimal_exponent_i (out_o.decimal_exponent)
);
